### hw/rtl/jtl_pkg.sv
// Shared types, token codes and literal tables for the JSON token lexer.
`default_nettype none

package jtl_pkg;

  localparam int POS_BITS = 32;
  localparam int MAX_RES  = 3;
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef logic [POS_BITS-1:0] pos_t;

  localparam logic [3:0] KIND_END    = 4'd0;
  localparam logic [3:0] KIND_LBRACK = 4'd1;
  localparam logic [3:0] KIND_RBRACK = 4'd2;
  localparam logic [3:0] KIND_LBRACE = 4'd3;
  localparam logic [3:0] KIND_RBRACE = 4'd4;
  localparam logic [3:0] KIND_COLON  = 4'd5;
  localparam logic [3:0] KIND_COMMA  = 4'd6;
  localparam logic [3:0] KIND_TRUE   = 4'd7;
  localparam logic [3:0] KIND_NULL   = 4'd9;
  localparam logic [3:0] KIND_NUMBER = 4'd10;
  localparam logic [3:0] KIND_STRING = 4'd11;
  localparam logic [3:0] KIND_SPACE  = 4'd12;
  localparam logic [3:0] KIND_ERROR  = 4'd13;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_UNKNOWN = 2'd1;
  localparam logic [1:0] CAUSE_LITERAL = 2'd2;
  localparam logic [1:0] CAUSE_UNTERM  = 2'd3;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_LIT     = 7'b0000010,
    PH_INT     = 7'b0000100,
    PH_DOT     = 7'b0001000,
    PH_FRAC    = 7'b0010000,
    PH_STR     = 7'b0100000,
    PH_SWALLOW = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] cause;
    pos_t       start;
    pos_t       len;
    logic       last;
  } res_t;

  function automatic res_t mk_res(logic [3:0] kind, logic [1:0] cause, pos_t start, pos_t len);
    res_t r;
    r.kind  = kind;
    r.cause = cause;
    r.start = start;
    r.len   = len;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] which);
    return (which == LIT_FALSE) ? 3'd4 : 3'd3;
  endfunction

  // Expected byte after the first letter of each literal.
  function automatic logic [7:0] lit_char(logic [1:0] which, logic [1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (which)
      LIT_TRUE: begin
        unique case (idx)
          2'd0: c = "r";
          2'd1: c = "u";
          2'd2: c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (idx)
          2'd0: c = "a";
          2'd1: c = "l";
          2'd2: c = "s";
          default: c = "e";
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: c = "u";
          2'd1: c = "l";
          2'd2: c = "l";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

endpackage

`default_nettype wire

### hw/rtl/jtl_res_fifo.sv
// Result queue that takes up to three results per cycle and releases one.
`default_nettype none

module jtl_res_fifo (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [1:0]              push_n_i,
  input  wire jtl_pkg::res_t           push_i [jtl_pkg::MAX_RES],
  input  wire logic                    pop_i,
  output jtl_pkg::res_t                head_o,
  output logic                         valid_o,
  output logic [jtl_pkg::RQ_CW-1:0]    count_o
);
  import jtl_pkg::*;

  res_t             mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] head_q, head_d;
  logic [RQ_AW-1:0] tail_q, tail_d;
  logic [RQ_CW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign head_o  = mem_q[head_q];
  assign count_o = cnt_q;

  always_comb begin
    head_d = head_q + RQ_AW'(pop);
    tail_d = tail_q + RQ_AW'(push_n_i);
    cnt_d  = cnt_q + RQ_CW'(push_n_i) - RQ_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RQ_CW'(i) < RQ_CW'(push_n_i)) begin
        mem_q[tail_q + RQ_AW'(i)] <= push_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= RQ_CW'(RQ_DEPTH))
    else $error("Result queue count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) && !pop |=> cnt_q == $past(cnt_q) + RQ_CW'($past(push_n_i)))
    else $error("Result queue lost or invented a word.");

endmodule

`default_nettype wire

### hw/rtl/json_token_lexer.sv
// Streaming JSON token lexer: one source byte per word in, token records out.
//
// The input channel carries one word per byte of JSON text (mode_i low), or
// an end-of-source word (mode_i high) that flushes any open token, reports an
// end token and returns the lexer to offset zero. The output channel carries
// one token record per word: kind, error cause, start offset, length and a
// flag on the last record caused by a given input word.
// An input word is captured in an input register and lexed once the result
// queue holds at most one record; its zero to three records are then written
// into a four-entry result queue. One input word is taken every cycle as long
// as the queue holds at most one record, so the rate is one byte per cycle
// while each byte yields at most one record and the receiver keeps up; a word
// that yields two or three records holds input ready low until the single
// read port of the result queue has brought it back to at most one record.
// When the receiver stalls, the queue fills and input ready drops; no record
// is lost. Reset empties the queue and the input register and starts a new
// source at offset zero.
`default_nettype none

module json_token_lexer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  text_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       token_kind_o,
  output logic [1:0]       error_cause_o,
  output logic [31:0]      start_offset_o,
  output logic [31:0]      token_length_o,
  output logic             last_of_run_o
);
  import jtl_pkg::*;

  logic             s1_valid_q;
  logic             mode_q;
  logic [7:0]       byte_q;
  logic             proc;
  logic             in_fire;

  phase_e           phase_q, phase_d;
  logic [1:0]       which_q, which_d;
  logic [2:0]       prog_q, prog_d;
  pos_t             pos_q, pos_d;
  pos_t             beg_q, beg_d;

  res_t             f_res;
  logic             f_emit;
  phase_e           f_phase;
  logic             f_lit;
  logic             f_start;
  logic [1:0]       f_which;

  res_t             pre0, pre1, tail_res;
  logic [1:0]       pre_n;
  logic             tail_en;
  logic [1:0]       res_n;
  res_t             slots [MAX_RES];
  logic [1:0]       push_n;
  logic [RQ_CW-1:0] q_count;
  res_t             q_head;
  logic             lit_hit;
  logic [2:0]       lit_next;

  assign proc       = s1_valid_q && (q_count <= RQ_CW'(RQ_DEPTH - MAX_RES));
  assign in_ready_o = !s1_valid_q || proc;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_i;
      byte_q <= text_byte_i;
    end
  end

  // Classification of a byte that starts a new token.
  always_comb begin
    f_emit  = 1'b1;
    f_phase = PH_IDLE;
    f_lit   = 1'b0;
    f_start = 1'b0;
    f_which = LIT_TRUE;
    f_res   = mk_res(KIND_ERROR, CAUSE_UNKNOWN, pos_q, pos_t'(1));
    priority case (byte_q)
      "[": f_res.kind = KIND_LBRACK;
      "]": f_res.kind = KIND_RBRACK;
      "{": f_res.kind = KIND_LBRACE;
      "}": f_res.kind = KIND_RBRACE;
      ":": f_res.kind = KIND_COLON;
      ",": f_res.kind = KIND_COMMA;
      " ", 8'h0d, 8'h0a, 8'h09: f_res.kind = KIND_SPACE;
      "t", "f", "n": begin
        f_emit  = 1'b0;
        f_phase = PH_LIT;
        f_lit   = 1'b1;
        f_start = 1'b1;
        f_which = (byte_q == "t") ? LIT_TRUE : (byte_q == "f") ? LIT_FALSE : LIT_NULL;
      end
      "\"": begin
        f_emit  = 1'b0;
        f_phase = PH_STR;
        f_start = 1'b1;
      end
      default: begin
        if (byte_q == "-" || is_digit(byte_q)) begin
          f_emit  = 1'b0;
          f_phase = PH_INT;
          f_start = 1'b1;
        end
      end
    endcase
    if (f_res.kind != KIND_ERROR) begin
      f_res.cause = CAUSE_NONE;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    which_d  = which_q;
    prog_d   = prog_q;
    pos_d    = pos_q;
    beg_d    = beg_q;
    pre0     = mk_res(KIND_NUMBER, CAUSE_NONE, beg_q, pos_q - beg_q);
    pre1     = mk_res(KIND_ERROR, CAUSE_UNKNOWN, pos_q - pos_t'(1), pos_t'(1));
    pre_n    = 2'd0;
    tail_en  = 1'b0;
    tail_res = f_res;
    lit_hit  = (prog_q < lit_len(which_q)) && (byte_q == lit_char(which_q, prog_q[1:0]));
    lit_next = prog_q + 3'd1;

    if (mode_q) begin
      unique case (phase_q)
        PH_LIT: begin
          pre0  = mk_res(KIND_ERROR, CAUSE_LITERAL, beg_q, pos_q - beg_q);
          pre_n = 2'd1;
        end
        PH_INT, PH_FRAC: pre_n = 2'd1;
        PH_DOT: begin
          pre0.len = pos_q - pos_t'(1) - beg_q;
          pre_n    = 2'd2;
        end
        PH_STR: begin
          pre0  = mk_res(KIND_ERROR, CAUSE_UNTERM, beg_q, pos_q - beg_q);
          pre_n = 2'd1;
        end
        default: pre_n = 2'd0;
      endcase
      tail_en  = 1'b1;
      tail_res = mk_res(KIND_END, CAUSE_NONE, pos_q, '0);
      phase_d  = PH_IDLE;
      which_d  = LIT_TRUE;
      prog_d   = '0;
      pos_d    = '0;
      beg_d    = '0;
    end else begin
      pos_d = pos_q + pos_t'(1);
      unique case (phase_q)
        PH_LIT: begin
          if (lit_hit) begin
            prog_d = lit_next;
            if (lit_next >= lit_len(which_q)) begin
              pre0 = mk_res((which_q == 2'd3) ? KIND_NULL : KIND_TRUE + {2'b00, which_q},
                            CAUSE_NONE, beg_q, pos_t'(lit_next) + pos_t'(1));
              pre_n   = 2'd1;
              phase_d = PH_IDLE;
            end
          end else begin
            pre0    = mk_res(KIND_ERROR, CAUSE_LITERAL, beg_q, pos_q + pos_t'(1) - beg_q);
            pre_n   = 2'd1;
            phase_d = PH_SWALLOW;
          end
        end
        PH_INT, PH_FRAC: begin
          if (is_digit(byte_q)) begin
            phase_d = phase_q;
          end else if (phase_q == PH_INT && byte_q == ".") begin
            phase_d = PH_DOT;
          end else begin
            pre_n   = 2'd1;
            tail_en = f_emit;
            phase_d = f_phase;
            if (f_lit) begin
              which_d = f_which;
              prog_d  = '0;
            end
            if (f_start) begin
              beg_d = pos_q;
            end
          end
        end
        PH_DOT: begin
          if (is_digit(byte_q)) begin
            phase_d = PH_FRAC;
          end else begin
            pre0.len = pos_q - pos_t'(1) - beg_q;
            pre_n    = 2'd2;
            tail_en  = f_emit;
            phase_d  = f_phase;
            if (f_lit) begin
              which_d = f_which;
              prog_d  = '0;
            end
            if (f_start) begin
              beg_d = pos_q;
            end
          end
        end
        PH_STR: begin
          if (byte_q == "\"") begin
            pre0    = mk_res(KIND_STRING, CAUSE_NONE, beg_q, pos_q + pos_t'(1) - beg_q);
            pre_n   = 2'd1;
            phase_d = PH_IDLE;
          end
        end
        PH_SWALLOW: phase_d = PH_SWALLOW;
        default: begin
          tail_en = f_emit;
          phase_d = f_phase;
          if (f_lit) begin
            which_d = f_which;
            prog_d  = '0;
          end
          if (f_start) begin
            beg_d = pos_q;
          end
        end
      endcase
    end
  end

  // Pending records come first, then the record of the byte itself.
  always_comb begin
    res_n    = pre_n + 2'(tail_en);
    slots[0] = (pre_n >= 2'd1) ? pre0 : tail_res;
    slots[1] = (pre_n >= 2'd2) ? pre1 : tail_res;
    slots[2] = tail_res;
    for (int i = 0; i < MAX_RES; i++) begin
      slots[i].last = (res_n != 2'd0) && (2'(i) == res_n - 2'd1);
    end
    push_n = proc ? res_n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      which_q <= LIT_TRUE;
      prog_q  <= '0;
      pos_q   <= '0;
      beg_q   <= '0;
    end else if (proc) begin
      phase_q <= phase_d;
      which_q <= which_d;
      prog_q  <= prog_d;
      pos_q   <= pos_d;
      beg_q   <= beg_d;
    end
  end

  jtl_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push_i   (slots),
    .pop_i    (out_ready_i),
    .head_o   (q_head),
    .valid_o  (out_valid_o),
    .count_o  (q_count)
  );

  assign token_kind_o   = q_head.kind;
  assign error_cause_o  = q_head.cause;
  assign start_offset_o = 32'(q_head.start);
  assign token_length_o = 32'(q_head.len);
  assign last_of_run_o  = q_head.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && mode_q |=> (pos_q == '0) && (phase_q == PH_IDLE))
    else $error("End word did not return the lexer to offset zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !mode_q |=> pos_q == $past(pos_q) + pos_t'(1))
    else $error("Byte offset did not advance by one on a data word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && mode_q |-> (push_n != 2'd0) && (slots[push_n - 2'd1].kind == KIND_END))
    else $error("End word did not close with an end token.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SWALLOW && proc && !mode_q |-> push_n == 2'd0)
    else $error("Record produced while swallowing after a literal error.");

endmodule

`default_nettype wire

### tb/sv/json_token_lexer_tb.sv
// Self-checking testbench for the streaming JSON token lexer.
`timescale 1ns / 100ps

module json_token_lexer_tb;
  import jtl_pkg::*;

  localparam bit MODE_BYTE = 1'b0;
  localparam bit MODE_END  = 1'b1;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_WORDS = 270;

  class lexer_scoreboard;
    res_t        token_queue[$];
    int unsigned mismatches;
    phase_e      phase;
    logic [1:0]  lit_sel;
    int unsigned lit_done;
    logic [31:0] next_pos;
    logic [31:0] tok_start;
    string       lit_tail[3];

    function new();
      lit_tail = '{"rue", "alse", "ull"};
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = PH_IDLE;
      lit_sel = LIT_TRUE;
      lit_done = 0;
      next_pos = '0;
      tok_start = '0;
    endfunction

    function void push_token(logic [3:0] kind, logic [1:0] cause, logic [31:0] start,
                             logic [31:0] len);
      res_t r;
      r.kind = kind;
      r.cause = cause;
      r.start = start;
      r.len = len;
      r.last = 1'b0;
      token_queue.push_back(r);
    endfunction

    function bit is_num_char(logic [7:0] b);
      return (b >= "0") && (b <= "9");
    endfunction

    function void lex_fresh(logic [7:0] b, logic [31:0] at);
      phase = PH_IDLE;
      case (b)
        "[": push_token(KIND_LBRACK, CAUSE_NONE, at, 1);
        "]": push_token(KIND_RBRACK, CAUSE_NONE, at, 1);
        "{": push_token(KIND_LBRACE, CAUSE_NONE, at, 1);
        "}": push_token(KIND_RBRACE, CAUSE_NONE, at, 1);
        ":": push_token(KIND_COLON, CAUSE_NONE, at, 1);
        ",": push_token(KIND_COMMA, CAUSE_NONE, at, 1);
        " ", "\t", "\r", "\n": push_token(KIND_SPACE, CAUSE_NONE, at, 1);
        "t", "f", "n": begin
          lit_sel = (b == "t") ? LIT_TRUE : (b == "f") ? LIT_FALSE : LIT_NULL;
          lit_done = 0;
          tok_start = at;
          phase = PH_LIT;
        end
        "\"": begin
          tok_start = at;
          phase = PH_STR;
        end
        default: begin
          if (b == "-" || is_num_char(b)) begin
            tok_start = at;
            phase = PH_INT;
          end else begin
            push_token(KIND_ERROR, CAUSE_UNKNOWN, at, 1);
          end
        end
      endcase
    endfunction

    // Works out the token records caused by one accepted input word.
    function void note_word(bit is_end, logic [7:0] b);
      int unsigned prior_count;
      string       tail;
      res_t        r;
      prior_count = token_queue.size();
      if (is_end) begin
        case (phase)
          PH_LIT: push_token(KIND_ERROR, CAUSE_LITERAL, tok_start, next_pos - tok_start);
          PH_INT, PH_FRAC: push_token(KIND_NUMBER, CAUSE_NONE, tok_start, next_pos - tok_start);
          PH_DOT: begin
            push_token(KIND_NUMBER, CAUSE_NONE, tok_start, next_pos - 1 - tok_start);
            push_token(KIND_ERROR, CAUSE_UNKNOWN, next_pos - 1, 1);
          end
          PH_STR: push_token(KIND_ERROR, CAUSE_UNTERM, tok_start, next_pos - tok_start);
          default: ;
        endcase
        push_token(KIND_END, CAUSE_NONE, next_pos, 0);
        clear_state();
      end else begin
        case (phase)
          PH_LIT: begin
            tail = lit_tail[lit_sel];
            if (lit_done < tail.len() && b == tail[lit_done]) begin
              lit_done++;
              if (lit_done >= tail.len()) begin
                push_token(KIND_TRUE + 4'(lit_sel), CAUSE_NONE, tok_start, lit_done + 1);
                phase = PH_IDLE;
              end
            end else begin
              push_token(KIND_ERROR, CAUSE_LITERAL, tok_start, next_pos + 1 - tok_start);
              phase = PH_SWALLOW;
            end
          end
          PH_INT: begin
            if (b == ".") begin
              phase = PH_DOT;
            end else if (!is_num_char(b)) begin
              push_token(KIND_NUMBER, CAUSE_NONE, tok_start, next_pos - tok_start);
              lex_fresh(b, next_pos);
            end
          end
          PH_DOT: begin
            if (is_num_char(b)) begin
              phase = PH_FRAC;
            end else begin
              push_token(KIND_NUMBER, CAUSE_NONE, tok_start, next_pos - 1 - tok_start);
              push_token(KIND_ERROR, CAUSE_UNKNOWN, next_pos - 1, 1);
              lex_fresh(b, next_pos);
            end
          end
          PH_FRAC: begin
            if (!is_num_char(b)) begin
              push_token(KIND_NUMBER, CAUSE_NONE, tok_start, next_pos - tok_start);
              lex_fresh(b, next_pos);
            end
          end
          PH_STR: begin
            if (b == "\"") begin
              push_token(KIND_STRING, CAUSE_NONE, tok_start, next_pos + 1 - tok_start);
              phase = PH_IDLE;
            end
          end
          PH_SWALLOW: ;
          default: lex_fresh(b, next_pos);
        endcase
        next_pos = next_pos + 1;
      end
      if (token_queue.size() > prior_count) begin
        r = token_queue.pop_back();
        r.last = 1'b1;
        token_queue.push_back(r);
      end
    endfunction

    function void check_record(logic [3:0] kind, logic [1:0] cause, logic [31:0] start,
                               logic [31:0] len, logic last);
      res_t r;
      if (token_queue.size() == 0) begin
        $error("unexpected token record: kind %0d at offset %0d", kind, start);
        mismatches++;
        return;
      end
      r = token_queue.pop_front();
      if (kind !== r.kind) begin
        $error("token_kind: expected %0d, got %0d", r.kind, kind);
        mismatches++;
      end
      if (cause !== r.cause) begin
        $error("error_cause: expected %0d, got %0d", r.cause, cause);
        mismatches++;
      end
      if (start !== r.start) begin
        $error("start_offset: expected %0d, got %0d", r.start, start);
        mismatches++;
      end
      if (len !== r.len) begin
        $error("token_length: expected %0d, got %0d", r.len, len);
        mismatches++;
      end
      if (last !== r.last) begin
        $error("last_of_run: expected %0d, got %0d", r.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        mode = MODE_BYTE;
  logic [7:0]  text_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [3:0]  token_kind_o;
  logic [1:0]  error_cause_o;
  logic [31:0] start_offset_o;
  logic [31:0] token_length_o;
  logic        last_of_run_o;

  lexer_scoreboard sb;
  int          burst_left = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  rx_tick = 8'h00;
  logic [1:0]  rx_style = 2'd0;
  string       punct = "[]{}:,";
  string       blanks = " \t\r\n";
  string       lit_words[3] = '{"true", "false", "null"};

  json_token_lexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode),
    .text_byte_i    (text_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind_o),
    .error_cause_o  (error_cause_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready_o) begin
      sb.note_word(mode, text_byte);
    end
    if (rst_ni && out_valid_o && out_ready) begin
      sb.check_record(token_kind_o, error_cause_o, start_offset_o, token_length_o,
                      last_of_run_o);
    end
  end

  // The receiver picks a new random stall style whenever the low six bits of its tick counter are zero.
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[5:0] == 6'd0) begin
      rx_style <= 2'($urandom_range(0, 3));
    end
    case (rx_style)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= (rx_tick[1:0] == 2'd0);
      default: out_ready <= rx_tick[3];
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(input bit word_mode, input logic [7:0] b);
    if (burst_left == 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= word_mode;
    text_byte <= b;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(MODE_BYTE, s[i]);
    end
  endtask

  task automatic send_end();
    send_word(MODE_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.token_queue.size() != 0);
  endtask

  task automatic send_digits(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(MODE_BYTE, 8'("0" + $urandom_range(0, 9)));
    end
  endtask

  // Sends one token, mostly well formed; sets broken after a failed literal.
  task automatic send_token(output bit broken);
    int         pick;
    int         k;
    string      lit;
    logic [7:0] b;
    broken = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      send_word(MODE_BYTE, punct[$urandom_range(0, 5)]);
    end else if (pick < 28) begin
      send_word(MODE_BYTE, blanks[$urandom_range(0, 3)]);
    end else if (pick < 43) begin
      send_text(lit_words[$urandom_range(0, 2)]);
    end else if (pick < 58) begin
      if ($urandom_range(0, 2) == 0) send_word(MODE_BYTE, "-");
      send_digits($urandom_range(1, 3));
      if ($urandom_range(0, 1) == 0) begin
        send_word(MODE_BYTE, ".");
        send_digits($urandom_range(1, 2));
      end
    end else if (pick < 73) begin
      send_word(MODE_BYTE, "\"");
      k = $urandom_range(0, 4);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(8'h80, 8'hFF));
        else b = 8'($urandom_range(8'h20, 8'h7E));
        send_word(MODE_BYTE, b);
      end
      send_word(MODE_BYTE, "\"");
    end else if (pick < 80) begin
      lit = lit_words[$urandom_range(0, 2)];
      k = $urandom_range(1, lit.len() - 1);
      send_text(lit.substr(0, k - 1));
      b = 8'($urandom_range(0, 255));
      if (b == lit[k]) b = b ^ 8'h20;
      send_word(MODE_BYTE, b);
      broken = 1'b1;
    end else if (pick < 87) begin
      send_digits($urandom_range(1, 2));
      send_word(MODE_BYTE, ".");
    end else if (pick < 95) begin
      send_word(MODE_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      send_text("--");
      send_digits($urandom_range(0, 1));
    end
  endtask

  task automatic send_source();
    int n_tokens;
    bit broken;
    n_tokens = $urandom_range(1, 10);
    for (int i = 0; i < n_tokens; i++) begin
      send_token(broken);
      if (broken) break;
    end
    if (!broken) begin
      case ($urandom_range(0, 7))
        0: send_text("fal");
        1: send_text("\"q");
        2: send_text("-4");
        3: send_text("9.");
        default: ;
      endcase
    end
    send_end();
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("[]{}:,\t\"a\"-1.x--");
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_BYTE, 8'h00);
    send_text("nul");
    send_end();
    send_text("tx");
    send_end();
    drain_wait();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      send_source();
      if ($urandom_range(0, 4) == 0) drain_wait();
    end

    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.token_queue.size() != 0) begin
      $error("%0d token records never arrived", sb.token_queue.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### json_token_lexer.f
hw/rtl/jtl_pkg.sv
hw/rtl/jtl_res_fifo.sv
hw/rtl/json_token_lexer.sv
tb/sv/json_token_lexer_tb.sv
